@@ hw/rtl/ils_pkg.sv @@
// Shared types and constants for the indexed list store.
package ils_pkg;

  localparam int CAPACITY_DEF   = 64;
  localparam int DATA_WIDTH_DEF = 32;

  localparam logic [1:0] OP_INSERT = 2'd0;
  localparam logic [1:0] OP_REMOVE = 2'd1;
  localparam logic [1:0] OP_GET    = 2'd2;
  localparam logic [1:0] OP_SET    = 2'd3;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_RANGE = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  typedef struct packed {
    logic [1:0]  operation;
    logic [6:0]  position;
    logic [31:0] data_in;
  } ils_in_t;

  typedef struct packed {
    logic [31:0] data_out;
    logic [1:0]  status;
    logic [6:0]  entry_count;
  } ils_out_t;

  // Broadcast to every cell: which kind of move happens this cycle.
  typedef struct packed {
    logic ins;   // open a slot at pos, later entries move up
    logic rem;   // close the slot at pos, later entries move down
    logic wr;    // overwrite the entry at pos
  } ils_cmd_t;

endpackage

@@ hw/rtl/ils_cell.sv @@
// One list slot: holds a word, shifts to or from its neighbors, offers it on a position match.
module ils_cell #(
  parameter int DATA_WIDTH = ils_pkg::DATA_WIDTH_DEF,
  parameter int PW         = 7,
  parameter int IDX        = 0
) (
  input  logic                  clk,
  input  ils_pkg::ils_cmd_t     cmd,
  input  logic [PW-1:0]         pos,
  input  logic [DATA_WIDTH-1:0] word,
  input  logic [DATA_WIDTH-1:0] left,
  input  logic [DATA_WIDTH-1:0] right,
  output logic [DATA_WIDTH-1:0] entry,
  output logic [DATA_WIDTH-1:0] read_word
);

  localparam logic [PW-1:0] MY_IDX = PW'(IDX);

  logic [DATA_WIDTH-1:0] entry_r;
  logic [DATA_WIDTH-1:0] entry_nxt;
  logic                  hit;

  assign hit = (pos == MY_IDX);

  always_comb begin
    entry_nxt = entry_r;
    if (cmd.ins) begin
      if (MY_IDX > pos) begin
        entry_nxt = left;
      end else if (hit) begin
        entry_nxt = word;
      end
    end else if (cmd.rem) begin
      if (MY_IDX >= pos) begin
        entry_nxt = right;
      end
    end else if (cmd.wr && hit) begin
      entry_nxt = word;
    end
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
  end

  assign entry     = entry_r;
  assign read_word = hit ? entry_r : '0;

endmodule

@@ hw/rtl/indexed_list_store.sv @@
// Indexed list store: position-addressed list built from a chain of word cells.
// A result is registered and appears in the cycle after its item is accepted, for one cycle.
// Throughput: one item per cycle; busy stays low, so no item is ever held off.
// The row of cells moves all entries at once, so insert and remove cost the same as get.
// Reset (synchronous, rst_n low) empties the list; cell contents are left as they are.
// The result strobe cannot be held off by the receiver.
module indexed_list_store #(
  parameter int CAPACITY   = ils_pkg::CAPACITY_DEF,
  parameter int DATA_WIDTH = ils_pkg::DATA_WIDTH_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  output logic             busy,
  input  ils_pkg::ils_in_t in_item,
  output logic             out_valid,
  output ils_pkg::ils_out_t out_item
);

  // Count width holds 0..CAPACITY; compares run at the wider of that and the position field.
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int PW = (CW > 7) ? CW : 7;
  localparam logic [PW-1:0] CAP = PW'(CAPACITY);

  logic [CW-1:0] cnt_r;
  logic [CW-1:0] cnt_nxt;
  logic          out_valid_r;
  ils_pkg::ils_out_t out_item_r;
  ils_pkg::ils_out_t res_nxt;

  logic                  accept;
  logic [PW-1:0]         pos_x;
  logic [PW-1:0]         cnt_x;
  logic [DATA_WIDTH-1:0] word;
  logic [DATA_WIDTH-1:0] rd_word;
  ils_pkg::ils_cmd_t     cmd;

  logic [DATA_WIDTH-1:0] entry_w [CAPACITY];
  logic [DATA_WIDTH-1:0] read_w  [CAPACITY];

  // Every operation completes in the accepting cycle.
  assign busy   = 1'b0;
  assign accept = start && !busy;

  assign pos_x = PW'(in_item.position);
  assign cnt_x = PW'(cnt_r);
  // Keep the low DATA_WIDTH bits of the item word, zero-extended if wider.
  assign word  = DATA_WIDTH'({32'b0, in_item.data_in});

  // Exactly one cell matches an in-range position; OR of the masked words picks it.
  always_comb begin
    rd_word = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      rd_word = rd_word | read_w[i];
    end
  end

  // Decode: range check first, then full check; only a clean op moves the cells.
  always_comb begin
    logic [1:0]  st;
    logic [31:0] dout;
    st      = ils_pkg::ST_OK;
    dout    = '0;
    cmd     = '0;
    cnt_nxt = cnt_r;
    case (in_item.operation)
      ils_pkg::OP_INSERT: begin
        if (pos_x > cnt_x) begin
          st = ils_pkg::ST_RANGE;
        end else if (cnt_x >= CAP) begin
          st = ils_pkg::ST_FULL;
        end else begin
          cmd.ins = 1'b1;
        end
      end
      ils_pkg::OP_REMOVE: begin
        if (pos_x >= cnt_x) begin
          st = ils_pkg::ST_RANGE;
        end else begin
          cmd.rem = 1'b1;
          dout    = 32'(64'(rd_word));
        end
      end
      ils_pkg::OP_GET: begin
        if (pos_x >= cnt_x) begin
          st = ils_pkg::ST_RANGE;
        end else begin
          dout = 32'(64'(rd_word));
        end
      end
      ils_pkg::OP_SET: begin
        if (pos_x < cnt_x) begin
          cmd.wr = 1'b1;
          dout   = 32'(64'(rd_word));
        end else if (pos_x > cnt_x) begin
          st = ils_pkg::ST_RANGE;
        end else if (cnt_x >= CAP) begin
          st = ils_pkg::ST_FULL;
        end else begin
          cmd.ins = 1'b1;   // append at the end
        end
      end
      default: begin
        st = ils_pkg::ST_RANGE;
      end
    endcase
    if (!accept) begin
      cmd = '0;
    end
    if (cmd.ins) begin
      cnt_nxt = cnt_r + CW'(1);
    end else if (cmd.rem) begin
      cnt_nxt = cnt_r - CW'(1);
    end
    res_nxt.data_out    = dout;
    res_nxt.status      = st;
    res_nxt.entry_count = 7'(cnt_nxt);
  end

  // The cell chain: each cell sees its two neighbors; the ends see zero.
  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    logic [DATA_WIDTH-1:0] left_w;
    logic [DATA_WIDTH-1:0] right_w;
    if (g == 0) begin : g_first
      assign left_w = '0;
    end else begin : g_mid_l
      assign left_w = entry_w[g-1];
    end
    if (g == CAPACITY - 1) begin : g_last
      assign right_w = '0;
    end else begin : g_mid_r
      assign right_w = entry_w[g+1];
    end
    ils_cell #(
      .DATA_WIDTH (DATA_WIDTH),
      .PW         (PW),
      .IDX        (g)
    ) u_cell (
      .clk       (clk),
      .cmd       (cmd),
      .pos       (pos_x),
      .word      (word),
      .left      (left_w),
      .right     (right_w),
      .entry     (entry_w[g]),
      .read_word (read_w[g])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= accept;
      if (accept) begin
        cnt_r <= cnt_nxt;
      end
    end
    if (accept) begin
      out_item_r <= res_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule

@@ sim/indexed_list_store_tb.sv @@
// Self-checking testbench for the indexed list store: directed and random list operations.
module indexed_list_store_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LIST_DEPTH = ils_pkg::CAPACITY_DEF;
  localparam int RANDOM_OPS = 450;
  localparam int BLOCK_OPS  = 56;

  // Stimulus flavor for a block of random operations.
  typedef enum logic [1:0] {GROW, SHRINK, CHURN} mix_t;

  // Tracks the list contents as the block should hold them and
  // checks each result against the oldest outstanding prediction.
  class list_tracker;
    logic [31:0]        words [0:LIST_DEPTH-1];
    int unsigned        used;
    ils_pkg::ils_out_t  pending_results [$];
    int unsigned        errors;

    function new();
      used   = 0;
      errors = 0;
    endfunction

    // Insert-style placement shared by insert and append-on-set.
    // Range check comes first, then the full check.
    function logic [1:0] place(int unsigned pos, logic [31:0] word);
      if (pos > used) return ils_pkg::ST_RANGE;
      if (used >= LIST_DEPTH) return ils_pkg::ST_FULL;
      for (int unsigned i = used; i > pos; i--) words[i] = words[i-1];
      words[pos] = word;
      used++;
      return ils_pkg::ST_OK;
    endfunction

    // Called once per accepted item; computes and queues its result.
    function void note_op(ils_pkg::ils_in_t op_item);
      ils_pkg::ils_out_t res;
      int unsigned       pos;
      pos          = op_item.position;
      res.data_out = '0;
      res.status   = ils_pkg::ST_OK;
      case (op_item.operation)
        ils_pkg::OP_INSERT: res.status = place(pos, op_item.data_in);
        ils_pkg::OP_REMOVE: begin
          if (pos >= used) begin
            res.status = ils_pkg::ST_RANGE;
          end else begin
            res.data_out = words[pos];
            for (int unsigned i = pos; i + 1 < used; i++) words[i] = words[i+1];
            used--;
          end
        end
        ils_pkg::OP_GET: begin
          if (pos >= used) res.status = ils_pkg::ST_RANGE;
          else res.data_out = words[pos];
        end
        default: begin // set
          if (pos < used) begin
            res.data_out = words[pos];
            words[pos]   = op_item.data_in;
          end else begin
            res.status = place(pos, op_item.data_in);
          end
        end
      endcase
      res.entry_count = used[6:0];
      pending_results.push_back(res);
    endfunction

    function void check_result(ils_pkg::ils_out_t got);
      ils_pkg::ils_out_t want;
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result %h", $time, got);
        errors++;
        return;
      end
      want = pending_results.pop_front();
      if (got.data_out !== want.data_out) begin
        $display("%0t: data_out expected %h actual %h", $time, want.data_out, got.data_out);
        errors++;
      end
      if (got.status !== want.status) begin
        $display("%0t: status expected %0d actual %0d", $time, want.status, got.status);
        errors++;
      end
      if (got.entry_count !== want.entry_count) begin
        $display("%0t: entry_count expected %0d actual %0d", $time,
                 want.entry_count, got.entry_count);
        errors++;
      end
    endfunction
  endclass

  logic              clk   = 1'b0;
  logic              rst_n = 1'b0;
  logic              start = 1'b0;
  logic              busy;
  ils_pkg::ils_in_t  in_item = '0;
  logic              out_valid;
  ils_pkg::ils_out_t out_item;

  list_tracker tracker = new();

  // When set, the sender runs back to back with no gaps at all.
  bit back_to_back = 1'b0;

  always #5 clk = ~clk;

  indexed_list_store u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_item  (out_item)
  );

  // Result side: a strobed result must be taken the cycle it shows up.
  always @(posedge clk) begin
    if (rst_n && out_valid) tracker.check_result(out_item);
  end

  // Sender gap: mostly none or short, occasionally long.
  function automatic int unsigned pick_gap();
    int unsigned r;
    if (back_to_back) return 0;
    r = $urandom_range(99);
    if (r < 50) return 0;
    if (r < 90) return $urandom_range(3, 1);
    return $urandom_range(30, 8);
  endfunction

  // Word values lean on the extremes now and then.
  function automatic logic [31:0] pick_word();
    int unsigned r;
    r = $urandom_range(9);
    if (r == 0) return '0;
    if (r == 1) return '1;
    return $urandom;
  endfunction

  // Random operation; positions mostly land in or just past the list,
  // the rest anywhere in the 7-bit field.
  function automatic ils_pkg::ils_in_t pick_op(mix_t mix, int unsigned depth_now);
    ils_pkg::ils_in_t op_item;
    int unsigned      r;
    r = $urandom_range(99);
    case (mix)
      GROW:    op_item.operation = (r < 60) ? ils_pkg::OP_INSERT :
                                   (r < 85) ? ils_pkg::OP_SET :
                                   (r < 95) ? ils_pkg::OP_GET : ils_pkg::OP_REMOVE;
      SHRINK:  op_item.operation = (r < 65) ? ils_pkg::OP_REMOVE :
                                   (r < 80) ? ils_pkg::OP_GET :
                                   (r < 90) ? ils_pkg::OP_SET : ils_pkg::OP_INSERT;
      default: op_item.operation = 2'($urandom_range(3));
    endcase
    if ($urandom_range(99) < 85) op_item.position = 7'($urandom_range(depth_now, 0));
    else op_item.position = 7'($urandom_range(127));
    op_item.data_in = pick_word();
    return op_item;
  endfunction

  // Hold the item on the inputs until it is taken, then maybe idle.
  task automatic send_op(input ils_pkg::ils_in_t op_item);
    int unsigned gap;
    start   <= 1'b1;
    in_item <= op_item;
    @(posedge clk);
    while (busy) @(posedge clk);
    tracker.note_op(op_item);
    gap = pick_gap();
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic send_fields(input logic [1:0] op, input logic [6:0] pos,
                             input logic [31:0] word);
    ils_pkg::ils_in_t op_item;
    op_item.operation = op;
    op_item.position  = pos;
    op_item.data_in   = word;
    send_op(op_item);
  endtask

  initial begin
    mix_t        mix_plan [8];
    int unsigned wait_cycles;

    // mix per block: grow toward full, mixed traffic, drain, mixed traffic, then grow and drain again
    mix_plan = '{GROW, GROW, CHURN, SHRINK, SHRINK, CHURN, GROW, SHRINK};

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: empty list, one-entry list, front/middle/end edits, wide positions.
    send_fields(ils_pkg::OP_GET,    7'd0,   32'h1111_1111); // empty get
    send_fields(ils_pkg::OP_REMOVE, 7'd0,   32'h0);         // empty remove
    send_fields(ils_pkg::OP_SET,    7'd5,   32'h2222_2222); // set past end on empty
    send_fields(ils_pkg::OP_SET,    7'd0,   32'hA5A5_0001); // append onto empty list
    send_fields(ils_pkg::OP_GET,    7'd0,   32'h0);
    send_fields(ils_pkg::OP_GET,    7'd1,   32'h0);         // one entry: index still honored
    send_fields(ils_pkg::OP_REMOVE, 7'd1,   32'h0);
    send_fields(ils_pkg::OP_INSERT, 7'd2,   32'h3333_3333); // insert past end
    send_fields(ils_pkg::OP_INSERT, 7'd1,   32'h0000_0000); // insert at end
    send_fields(ils_pkg::OP_INSERT, 7'd0,   32'hC0DE_0003); // insert at front
    send_fields(ils_pkg::OP_INSERT, 7'd1,   32'hFFFF_FFFF); // insert in the middle
    send_fields(ils_pkg::OP_SET,    7'd4,   32'h5A5A_5A5A); // append via set
    send_fields(ils_pkg::OP_SET,    7'd2,   32'h1234_5678); // replace, old word back
    send_fields(ils_pkg::OP_GET,    7'd127, 32'hFFFF_FFFF); // far out of range
    send_fields(ils_pkg::OP_GET,    7'd64,  32'h0);
    send_fields(ils_pkg::OP_REMOVE, 7'd1,   32'h0);         // remove middle
    send_fields(ils_pkg::OP_REMOVE, 7'd3,   32'h0);         // remove last
    send_fields(ils_pkg::OP_REMOVE, 7'd10,  32'h0);
    send_fields(ils_pkg::OP_SET,    7'd100, 32'hDEAD_BEEF); // set far past end
    send_fields(ils_pkg::OP_REMOVE, 7'd0,   32'h0);         // remove front
    send_fields(ils_pkg::OP_GET,    7'd1,   32'h0);

    // Random blocks; every third block runs without sender gaps.
    for (int unsigned n = 0; n < RANDOM_OPS; n++) begin
      if (n % BLOCK_OPS == 0) back_to_back = ((n / BLOCK_OPS) % 3 == 1);
      send_op(pick_op(mix_plan[(n / BLOCK_OPS) % 8], tracker.used));
    end
    back_to_back = 1'b0;
    start <= 1'b0;

    // Drain, then wait on for any stray strobe.
    wait_cycles = 0;
    while (tracker.pending_results.size() != 0 && wait_cycles < 1000) begin
      @(posedge clk);
      wait_cycles++;
    end
    repeat (5) @(posedge clk);

    if (tracker.errors == 0 && tracker.pending_results.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run.
  initial begin
    #2ms;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
